// ----- design/sexpr_token_lexer_macros.svh -----
// Assertion macros shared by the lexer RTL.
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SXL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SXL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sxl_pkg.sv -----
package sxl_pkg;

  // Field widths
  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = 16;
  localparam int VALUE_BITS  = 31;
  localparam int KIND_BITS   = 4;
  localparam int KW_BITS     = 3;
  localparam int NUM_KW      = 5;

  // Output queue
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LPAREN    = 4'd0,
    KIND_RPAREN    = 4'd1,
    KIND_LBRACK    = 4'd2,
    KIND_RBRACK    = 4'd3,
    KIND_LBRACE    = 4'd4,
    KIND_RBRACE    = 4'd5,
    KIND_QUOTE     = 4'd6,
    KIND_DQUOTE    = 4'd7,
    KIND_COLON     = 4'd8,
    KIND_BACKSLASH = 4'd9,
    KIND_IDENT     = 4'd10,
    KIND_INTEGER   = 4'd11,
    KIND_DONE      = 4'd12
  } kind_t;

  typedef enum logic [KW_BITS-1:0] {
    KW_NONE   = 3'd0,
    KW_PUB    = 3'd1,
    KW_DEF    = 3'd2,
    KW_VAR    = 3'd3,
    KW_PROC   = 3'd4,
    KW_RETURN = 3'd5
  } kw_t;

  // Keyword spelling, padded to eight bytes
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h70, 8'h75, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // pub
    '{8'h64, 8'h65, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // def
    '{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // var
    '{8'h70, 8'h72, 8'h6f, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00},  // proc
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00}   // return
  };
  localparam logic [LEN_BITS-1:0] KW_LEN [NUM_KW] = '{
    16'd3, 16'd3, 16'd3, 16'd4, 16'd6
  };

  localparam logic [VALUE_BITS-1:0] INT_MAX = '1;

  // One result word
  typedef struct packed {
    kind_t                   kind;
    kw_t                     kw;
    logic [VALUE_BITS-1:0]   value;
    logic                    sat;
    logic [LINE_BITS-1:0]    line;
    logic [COLUMN_BITS-1:0]  column;
    logic [OFFSET_BITS-1:0]  offset;
    logic [LEN_BITS-1:0]     length;
    logic                    last;
  } token_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } single_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // One-character token lookup
  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit = 1'b1;
    case (c)
      8'h28:   s.kind = KIND_LPAREN;
      8'h29:   s.kind = KIND_RPAREN;
      8'h5b:   s.kind = KIND_LBRACK;
      8'h5d:   s.kind = KIND_RBRACK;
      8'h7b:   s.kind = KIND_LBRACE;
      8'h7d:   s.kind = KIND_RBRACE;
      8'h27:   s.kind = KIND_QUOTE;
      8'h22:   s.kind = KIND_DQUOTE;
      8'h3a:   s.kind = KIND_COLON;
      8'h5c:   s.kind = KIND_BACKSLASH;
      default: begin
        s.hit  = 1'b0;
        s.kind = KIND_IDENT;
      end
    endcase
    return s;
  endfunction

  // Narrow the keyword candidates by one character at position pos
  function automatic logic [NUM_KW-1:0] mask_step(input logic [NUM_KW-1:0] mask,
                                                   input logic [LEN_BITS-1:0] pos,
                                                   input logic [7:0] c);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (mask[i] && (pos < KW_LEN[i]) && (KW_TEXT[i][pos[2:0]] == c)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ----- design/sexpr_token_lexer.sv -----
// A token word enters the output queue when the byte that completes it is accepted.
// One byte per cycle; a byte that closes a word and also makes a token of its own
// (bracket, end of text) yields two words, drained one per cycle unless out_stall,
// from a four-word output queue that takes a byte while it holds two or fewer.
// Reset (rst, synchronous): queue empty, position at line 1, column 0, offset 0.
module sexpr_token_lexer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       text_byte,
  input  logic                             end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sxl_pkg::KIND_BITS-1:0]    token_kind,
  output logic [sxl_pkg::KW_BITS-1:0]      keyword_id,
  output logic [sxl_pkg::VALUE_BITS-1:0]   int_value,
  output logic                             int_saturated,
  output logic [sxl_pkg::LINE_BITS-1:0]    start_line,
  output logic [sxl_pkg::COLUMN_BITS-1:0]  start_column,
  output logic [sxl_pkg::OFFSET_BITS-1:0]  start_offset,
  output logic [sxl_pkg::LEN_BITS-1:0]     token_length,
  output logic                             last_of_run
);
  import sxl_pkg::*;
  `include "sexpr_token_lexer_macros.svh"

  // Lexer state
  logic                   in_word;
  logic                   word_is_number;
  logic                   digits_active;
  logic [VALUE_BITS-1:0]  number_accum;
  logic                   number_clamped;
  logic [NUM_KW-1:0]      keyword_match_mask;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [LINE_BITS-1:0]   word_start_line;
  logic [COLUMN_BITS-1:0] word_start_column;
  logic [OFFSET_BITS-1:0] word_start_offset;
  logic [LEN_BITS-1:0]    word_length;

  logic                   in_word_next;
  logic                   word_is_number_next;
  logic                   digits_active_next;
  logic [VALUE_BITS-1:0]  number_accum_next;
  logic                   number_clamped_next;
  logic [NUM_KW-1:0]      keyword_match_mask_next;
  logic [LINE_BITS-1:0]   line_count_next;
  logic [COLUMN_BITS-1:0] column_count_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [LINE_BITS-1:0]   word_start_line_next;
  logic [COLUMN_BITS-1:0] word_start_column_next;
  logic [OFFSET_BITS-1:0] word_start_offset_next;
  logic [LEN_BITS-1:0]    word_length_next;

  // Output queue
  token_t                   fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_CNT_BITS-1:0] fifo_count;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] push_n;
  token_t     tok_a;
  token_t     tok_b;
  token_t     head;

  // Per-byte decode
  logic       ws;
  logic       digit;
  single_t    sk;
  logic       flush_en;
  logic       second_en;
  token_t     word_tok;
  token_t     second_tok;
  logic [VALUE_BITS+3:0] accum_x10;

  assign in_stall  = (fifo_count > FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (fifo_count != '0);
  assign out_acc   = out_valid && !out_stall;

  assign ws    = is_ws(text_byte);
  assign digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign sk    = single_kind(text_byte);

  // Pending word ends on whitespace, a bracket or end of text
  assign flush_en  = in_word && (end_of_text || ws ||
                     (sk.hit && (sk.kind <= KIND_RBRACE)));
  // Own token: done, or a one-character token outside a word or a bracket ending one
  assign second_en = end_of_text || (sk.hit && (!in_word || flush_en));

  assign accum_x10 = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0} +
                     {31'd0, text_byte[3:0] & {4{digit}}};

  // Word token from the pending word
  always_comb begin
    logic found;
    found            = 1'b0;
    word_tok         = '0;
    word_tok.line    = word_start_line;
    word_tok.column  = word_start_column;
    word_tok.offset  = word_start_offset;
    word_tok.length  = word_length;
    word_tok.last    = !second_en;
    word_tok.kw      = KW_NONE;
    if (word_is_number) begin
      word_tok.kind  = KIND_INTEGER;
      word_tok.value = number_accum;
      word_tok.sat   = number_clamped;
    end else begin
      word_tok.kind  = KIND_IDENT;
      for (int i = 0; i < NUM_KW; i++) begin
        if (!found && keyword_match_mask[i] && (word_length == KW_LEN[i])) begin
          found       = 1'b1;
          word_tok.kw = kw_t'(KW_BITS'(i + 1));
        end
      end
    end
  end

  // Done token or one-character token
  always_comb begin
    second_tok        = '0;
    second_tok.kw     = KW_NONE;
    second_tok.line   = line_count;
    second_tok.column = column_count;
    second_tok.offset = byte_offset;
    second_tok.last   = 1'b1;
    if (end_of_text) begin
      second_tok.kind   = KIND_DONE;
      second_tok.length = '0;
    end else begin
      second_tok.kind   = sk.kind;
      second_tok.length = LEN_BITS'(1);
    end
  end

  assign tok_a  = flush_en ? word_tok : second_tok;
  assign tok_b  = second_tok;
  assign push_n = in_acc ? ({1'b0, flush_en} + {1'b0, second_en}) : 2'd0;

  // Next state
  always_comb begin
    in_word_next            = in_word;
    word_is_number_next     = word_is_number;
    digits_active_next      = digits_active;
    number_accum_next       = number_accum;
    number_clamped_next     = number_clamped;
    keyword_match_mask_next = keyword_match_mask;
    word_start_line_next    = word_start_line;
    word_start_column_next  = word_start_column;
    word_start_offset_next  = word_start_offset;
    word_length_next        = word_length;
    line_count_next         = line_count;
    column_count_next       = column_count;
    byte_offset_next        = byte_offset;

    if (end_of_text) begin
      in_word_next            = 1'b0;
      word_is_number_next     = 1'b0;
      digits_active_next      = 1'b0;
      number_accum_next       = '0;
      number_clamped_next     = 1'b0;
      keyword_match_mask_next = '1;
      word_start_line_next    = LINE_BITS'(1);
      word_start_column_next  = '0;
      word_start_offset_next  = '0;
      word_length_next        = '0;
      line_count_next         = LINE_BITS'(1);
      column_count_next       = '0;
      byte_offset_next        = '0;
    end else begin
      if (flush_en) begin
        in_word_next = 1'b0;
      end else if (in_word) begin
        // extend the pending word
        if (digits_active && digit) begin
          if (accum_x10 > {4'd0, INT_MAX}) begin
            number_accum_next   = INT_MAX;
            number_clamped_next = 1'b1;
          end else begin
            number_accum_next   = accum_x10[VALUE_BITS-1:0];
          end
        end else begin
          digits_active_next = 1'b0;
        end
        keyword_match_mask_next = mask_step(keyword_match_mask, word_length, text_byte);
        if (word_length != '1) begin
          word_length_next = word_length + LEN_BITS'(1);
        end
      end else if (!ws && !sk.hit) begin
        // start a new word
        in_word_next            = 1'b1;
        word_is_number_next     = digit;
        digits_active_next      = digit;
        number_accum_next       = digit ? VALUE_BITS'(text_byte[3:0]) : '0;
        number_clamped_next     = 1'b0;
        keyword_match_mask_next = mask_step('1, '0, text_byte);
        word_length_next        = LEN_BITS'(1);
        word_start_line_next    = line_count;
        word_start_column_next  = column_count;
        word_start_offset_next  = byte_offset;
      end

      // position tracking, saturating
      if (byte_offset != '1) begin
        byte_offset_next = byte_offset + OFFSET_BITS'(1);
      end
      if (text_byte == 8'd10) begin
        if (line_count != '1) begin
          line_count_next = line_count + LINE_BITS'(1);
        end
        column_count_next = '0;
      end else if (column_count != '1) begin
        column_count_next = column_count + COLUMN_BITS'(1);
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word            <= 1'b0;
      word_is_number     <= 1'b0;
      digits_active      <= 1'b0;
      number_accum       <= '0;
      number_clamped     <= 1'b0;
      keyword_match_mask <= '1;
      line_count         <= LINE_BITS'(1);
      column_count       <= '0;
      byte_offset        <= '0;
      word_start_line    <= LINE_BITS'(1);
      word_start_column  <= '0;
      word_start_offset  <= '0;
      word_length        <= '0;
    end else if (in_acc) begin
      in_word            <= in_word_next;
      word_is_number     <= word_is_number_next;
      digits_active      <= digits_active_next;
      number_accum       <= number_accum_next;
      number_clamped     <= number_clamped_next;
      keyword_match_mask <= keyword_match_mask_next;
      line_count         <= line_count_next;
      column_count       <= column_count_next;
      byte_offset        <= byte_offset_next;
      word_start_line    <= word_start_line_next;
      word_start_column  <= word_start_column_next;
      word_start_offset  <= word_start_offset_next;
      word_length        <= word_length_next;
    end
  end

  // Queue storage: up to two words written per byte
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= tok_a;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_PTR_BITS'(1)] <= tok_b;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_PTR_BITS'(push_n);
      rd_ptr     <= rd_ptr + FIFO_PTR_BITS'(out_acc);
      fifo_count <= fifo_count + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(out_acc);
    end
  end

  // Head word to the output ports
  assign head          = fifo_mem[rd_ptr];
  assign token_kind    = head.kind;
  assign keyword_id    = head.kw;
  assign int_value     = head.value;
  assign int_saturated = head.sat;
  assign start_line    = head.line;
  assign start_column  = head.column;
  assign start_offset  = head.offset;
  assign token_length  = head.length;
  assign last_of_run   = head.last;

  // Checks
  `SXL_ASSERT_NEXT(a_eot_resets_position, in_acc && end_of_text,
    (line_count == LINE_BITS'(1)) && (column_count == '0) && (byte_offset == '0),
    "position not cleared after end of text")
  `SXL_ASSERT_NOW(a_done_is_last, out_valid && (token_kind == KIND_DONE),
    last_of_run && (token_length == '0), "done word malformed")
  `SXL_ASSERT_NEXT(a_count_tracks, 1'b1,
    fifo_count == $past(fifo_count) + FIFO_CNT_BITS'($past(push_n))
                  - FIFO_CNT_BITS'($past(out_acc)),
    "queue count mismatch")
  `SXL_ASSERT_NOW(a_no_overflow, 1'b1,
    fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue overflow")

endmodule
